FILE: src/gclc_pkg.sv
// Shared types, constants and helper functions of the gated causal long convolution unit.
package gclc_pkg;

  localparam logic [63:0] DEFAULT_SEED = 64'hA0C0FEE0A0C0FEE0;
  localparam logic [16:0] ONE_Q16      = 17'h10000;
  localparam int          XS_SHIFT_A   = 13;
  localparam int          XS_SHIFT_B   = 7;
  localparam int          XS_SHIFT_C   = 17;
  localparam int          FRAC_BITS    = 16;

  localparam logic [16:0] RESET_GAMMA  = 17'd58982;
  localparam logic [30:0] RESET_CLAMP  = 31'd8388608;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SEED   = 2'd0;
  localparam logic [1:0] CFG_GAMMA  = 2'd1;
  localparam logic [1:0] CFG_CLAMP  = 2'd2;
  localparam logic [1:0] CFG_BYPASS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GEN_DRAW,
    S_GEN_WAIT,
    S_GATE_DRAW,
    S_CONV,
    S_CONV_DRAIN,
    S_CLAMP1,
    S_GMUL,
    S_GATE_WAIT,
    S_CLAMP2,
    S_DONE
  } state_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul;   // Form a product of the operands in this cycle.
    logic load;  // The product replaces the accumulator instead of adding to it.
  } mac_ctl_t;

  function automatic logic [63:0] xorshift_next(input logic [63:0] st);
    logic [63:0] v;
    v = st;
    v = v ^ (v << XS_SHIFT_A);
    v = v ^ (v >> XS_SHIFT_B);
    v = v ^ (v << XS_SHIFT_C);
    return v;
  endfunction

  // Symmetric saturation of a 64-bit two's complement value to +-lim.
  function automatic logic signed [31:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic [30:0] lim);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed({33'b0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

endpackage

FILE: src/gclc_mac.sv
// Shared multiply-accumulate unit: registered 33x33 product followed by a 64-bit accumulator.
module gclc_mac import gclc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mac_ctl_t           ctl,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic [63:0]        acc,
  output logic               busy
);

  logic signed [65:0] prod_full;
  logic [63:0]        prod;
  logic               prod_vld;
  logic               prod_load;

  assign prod_full = op_a * op_b;
  assign busy      = prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld  <= 1'b0;
      prod_load <= 1'b0;
    end else begin
      prod_vld  <= ctl.mul;
      prod_load <= ctl.load;
    end
  end

  // The accumulator wraps modulo 2^64.
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= prod_full[63:0];
    end
    if (prod_vld) begin
      acc <= prod_load ? prod : acc + prod;
    end
  end

endmodule

FILE: src/gated_causal_long_convolution_unit.sv
// Top level of the gated causal long convolution unit: sequencer, stores and output register.
//
// Usage: an input beat carries command and sample. Command 0 feeds sample x[t] at the
// current sequence position t and returns y[t]; command 1 regenerates the filter taps and
// gates from the seed register, clears the position and the violation counter, and
// returns a beat of zeros. Every input beat yields exactly one result beat.
// The input is stalled while an item is in work; one item is worked on at a time.
// A sample at position t streams taps and history through the one shared multiply-accumulate
// unit, then passes the pipeline drain, clamping and the gate product (the gate product is
// skipped in bypass mode). For each tap a regeneration waits for the shared multiplier to
// form the next envelope power, then one gate is drawn per cycle.
// The finished beat sits in an output register, so a stalled receiver only holds the
// sequencer in its last step; the next input beat is taken once that register is free.
// Reset (synchronous, active high) restores the configuration defaults, clears the
// position and counter, and marks the filter and gates as zero until the first
// regeneration. Configuration writes are taken in any cycle without waiting.
module gated_causal_long_convolution_unit import gclc_pkg::*; #(
  parameter int TAPS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               command,
  input  logic signed [31:0] sample,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] result,
  output logic               saturated,
  output logic               last,
  output logic [31:0]        violation_count
);

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TAPS - 1);

  // Configuration registers.
  logic [63:0] seed;
  logic [16:0] decay_gamma;
  logic [30:0] clamp_limit;
  logic        bypass_gate;

  // Sequencer state and working registers.
  state_t             state;
  state_t             state_next;
  logic [IW-1:0]      k;
  logic [IW-1:0]      pos;
  logic [31:0]        viol;
  logic [63:0]        rng;
  logic [16:0]        env;
  logic signed [31:0] y;
  logic               gated;
  logic               cmd_q;
  // Set by the first regeneration; until then the taps and gates read as zero.
  logic               gen_done;

  // Stores.
  logic signed [31:0] tap_mem  [TAPS];
  logic [15:0]        gate_mem [TAPS];
  logic signed [31:0] hist_mem [TAPS];
  logic signed [31:0] tap_q;
  logic [15:0]        gate_q;
  logic signed [31:0] hist_q;
  logic [IW-1:0]      tap_raddr;
  logic [IW-1:0]      hist_raddr;

  // Read pipeline tags that follow the store reads into the multiplier.
  logic rd_issue;
  logic rd_first;
  logic rd_vld;
  logic rd_first_q;

  // Shared arithmetic unit.
  mac_ctl_t           mac_ctl;
  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic [63:0]        acc;
  logic               mac_busy;

  logic [63:0]        xs_val;
  logic [16:0]        gamma_eff;
  logic signed [31:0] tap_op;
  logic [15:0]        gate_op;
  logic signed [31:0] tap_wdata;
  logic signed [31:0] lim_pos;
  logic               hit;
  logic [31:0]        viol_new;
  logic               out_free;
  logic               accept;
  logic               pipe_idle;

  assign xs_val     = xorshift_next(rng);
  assign gamma_eff  = (decay_gamma > ONE_Q16) ? ONE_Q16 : decay_gamma;
  assign tap_op     = gen_done ? tap_q : 32'sd0;
  assign gate_op    = gen_done ? gate_q : 16'd0;
  assign tap_wdata  = xs_val[0] ? $signed({15'b0, env}) : -$signed({15'b0, env});
  assign lim_pos    = $signed({1'b0, clamp_limit});
  assign hit        = (y == lim_pos) || (y == -lim_pos);
  assign viol_new   = viol + {31'b0, gated && hit};
  assign out_free   = !res_valid || !res_stall;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign pipe_idle  = !rd_vld && !mac_busy;

  gclc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc),
    .busy (mac_busy)
  );

  // Store ports: one write and one registered read per store and cycle.
  always_ff @(posedge clk) begin
    if (state == S_GEN_DRAW) begin
      tap_mem[k] <= tap_wdata;
    end
    tap_q <= tap_mem[tap_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_GATE_DRAW) begin
      gate_mem[k] <= xs_val[15:0];
    end
    gate_q <= gate_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (accept && !command) begin
      hist_mem[pos] <= sample;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the operands of the shared unit.
  always_comb begin
    state_next   = state;
    tap_raddr    = k;
    hist_raddr   = pos - k;
    rd_issue     = 1'b0;
    rd_first     = (k == '0);
    op_a         = {tap_op[31], tap_op};
    op_b         = {hist_q[31], hist_q};
    mac_ctl.mul  = rd_vld;
    mac_ctl.load = rd_first_q;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = command ? S_GEN_DRAW : S_CONV;
        end
      end
      S_GEN_DRAW: begin
        op_a         = $signed({16'b0, env});
        op_b         = $signed({16'b0, gamma_eff});
        mac_ctl.mul  = 1'b1;
        mac_ctl.load = 1'b1;
        state_next   = S_GEN_WAIT;
      end
      S_GEN_WAIT: begin
        if (pipe_idle) begin
          state_next = (k == LAST_IDX) ? S_GATE_DRAW : S_GEN_DRAW;
        end
      end
      S_GATE_DRAW: begin
        if (k == LAST_IDX) begin
          state_next = S_DONE;
        end
      end
      S_CONV: begin
        rd_issue = 1'b1;
        if (k == pos) begin
          state_next = S_CONV_DRAIN;
        end
      end
      S_CONV_DRAIN: begin
        if (pipe_idle) begin
          state_next = S_CLAMP1;
        end
      end
      S_CLAMP1: begin
        state_next = bypass_gate ? S_DONE : S_GMUL;
      end
      S_GMUL: begin
        op_a         = {y[31], y};
        op_b         = $signed({17'b0, gate_op});
        mac_ctl.mul  = 1'b1;
        mac_ctl.load = 1'b1;
        state_next   = S_GATE_WAIT;
      end
      S_GATE_WAIT: begin
        if (pipe_idle) begin
          state_next = S_CLAMP2;
        end
      end
      S_CLAMP2: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration, control counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed        <= '0;
      decay_gamma <= RESET_GAMMA;
      clamp_limit <= RESET_CLAMP;
      bypass_gate <= 1'b0;
      gen_done    <= 1'b0;
      pos         <= '0;
      viol        <= '0;
      k           <= '0;
      rng         <= '0;
      rd_vld      <= 1'b0;
      rd_first_q  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      rd_vld     <= rd_issue;
      rd_first_q <= rd_issue && rd_first;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEED:   seed        <= cfg_data;
          CFG_GAMMA:  decay_gamma <= cfg_data[16:0];
          CFG_CLAMP:  clamp_limit <= cfg_data[30:0];
          CFG_BYPASS: bypass_gate <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            k <= '0;
            if (command) begin
              rng <= (seed == '0) ? DEFAULT_SEED : seed;
            end
          end
        end
        S_GEN_DRAW: begin
          rng <= xs_val;
        end
        S_GEN_WAIT: begin
          if (pipe_idle) begin
            k <= (k == LAST_IDX) ? '0 : k + 1'b1;
          end
        end
        S_GATE_DRAW: begin
          rng <= xs_val;
          if (k == LAST_IDX) begin
            gen_done <= 1'b1;
            pos      <= '0;
            viol     <= '0;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CONV: begin
          if (k != pos) begin
            k <= k + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            viol <= viol_new;
            if (!cmd_q) begin
              pos <= (pos == LAST_IDX) ? '0 : pos + 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      if (command) begin
        env <= ONE_Q16;
      end
    end
    if (state == S_GEN_WAIT && pipe_idle) begin
      env <= acc[32:16];
    end
    if (state == S_GATE_DRAW && k == LAST_IDX) begin
      y     <= '0;
      gated <= 1'b0;
    end
    if (state == S_CLAMP1) begin
      y     <= clamp_sym($signed(acc) >>> FRAC_BITS, clamp_limit);
      gated <= !bypass_gate;
    end
    if (state == S_CLAMP2) begin
      y <= clamp_sym($signed(acc) >>> FRAC_BITS, clamp_limit);
    end
    if (state == S_DONE && out_free) begin
      result          <= y;
      saturated       <= gated && hit;
      last            <= !cmd_q && (pos == LAST_IDX);
      violation_count <= viol_new;
    end
  end

endmodule

FILE: tb/sv/tb_gated_causal_long_convolution_unit.sv
// Self-checking testbench of the gated causal long convolution unit with a built-in predictor.
`timescale 1ns / 1ps

module tb_gated_causal_long_convolution_unit;
  import gclc_pkg::*;

  localparam int TAPS = 64;
  // The slowest legal gap between two accepted beats is a regeneration plus the longest sender
  // gap and the longest receiver stall. The watchdog allows several times that before it
  // declares the run hung.
  localparam int STUCK_LIMIT = 4 * (4 * TAPS + 1 + 16 + 16 + 16);
  localparam int ITEMS_PER_PHASE = 210;
  localparam int PHASE_COUNT = 8;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_REINIT = 1'b1
  } conv_cmd_e;

  // One input beat as the driver presents it.
  typedef struct packed {
    conv_cmd_e          cmd;
    logic signed [31:0] x;
  } conv_beat_t;

  // One result beat as the monitor expects it.
  typedef struct packed {
    logic signed [31:0] y;
    logic               sat;
    logic               last;
    logic [31:0]        viol;
  } conv_out_t;

  // Clock, reset and every input of the block start at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_SEED;
  logic [63:0]        cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               command = CMD_SAMPLE;
  logic signed [31:0] sample = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic signed [31:0] out_result;
  logic               out_saturated;
  logic               out_last;
  logic [31:0]        out_violations;

  gated_causal_long_convolution_unit #(
    .TAPS(TAPS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .command        (command),
    .sample         (sample),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .result         (out_result),
    .saturated      (out_saturated),
    .last           (out_last),
    .violation_count(out_violations)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Beats waiting to be driven, and result beats that the predictor has worked out but the
  // block has not yet delivered.
  conv_beat_t sample_beats_q[$];
  conv_out_t  conv_results_q[$];
  int         err_count = 0;
  int         stuck_cycles = 0;

  // Predictor copy of the configuration registers.
  logic [63:0] m_seed;
  logic [16:0] m_gamma;
  logic [30:0] m_clamp;
  logic        m_bypass;

  // Predictor copy of the block's stores and counters.
  logic signed [31:0] tap_mem[TAPS];
  logic [15:0]        gate_mem[TAPS];
  logic signed [31:0] hist_mem[TAPS];
  int                 seq_pos;
  logic [31:0]        viol_total;

  // One step of the 64-bit xorshift generator with shifts 13, 7 and 17.
  function automatic logic [63:0] xs64_step(input logic [63:0] s);
    s = s ^ (s << XS_SHIFT_A);
    s = s ^ (s >> XS_SHIFT_B);
    s = s ^ (s << XS_SHIFT_C);
    return s;
  endfunction

  // Symmetric saturation of a signed 64-bit value to plus or minus the clamp bound.
  function automatic longint bound_sym(input longint v, input logic [30:0] lim);
    longint hi;
    hi = longint'(lim);
    if (v > hi) return hi;
    if (v < -hi) return -hi;
    return v;
  endfunction

  // Works out the result beat of one accepted input beat and queues it. A reinit rebuilds
  // the tap and gate stores from the generator; a sample runs the causal convolution over
  // the current sequence, then the optional gate product.
  task automatic predict_beat(input conv_beat_t b);
    conv_out_t   o;
    logic [63:0] rng;
    logic [16:0] g;
    logic [31:0] env;
    longint      acc;
    longint      y;
    int          t;
    o = '0;
    if (b.cmd == CMD_REINIT) begin
      rng = (m_seed != '0) ? m_seed : DEFAULT_SEED;
      g = (m_gamma > ONE_Q16) ? ONE_Q16 : m_gamma;
      env = 32'(ONE_Q16);
      for (int k = 0; k < TAPS; k++) begin
        rng = xs64_step(rng);
        tap_mem[k] = rng[0] ? $signed(env) : -$signed(env);
        // The envelope power rounds toward minus infinity at every tap.
        env = 32'((64'(env) * 64'(g)) >> FRAC_BITS);
      end
      for (int k = 0; k < TAPS; k++) begin
        rng = xs64_step(rng);
        gate_mem[k] = rng[15:0];
      end
      seq_pos = 0;
      viol_total = '0;
    end else begin
      t = seq_pos;
      hist_mem[t] = b.x;
      acc = 0;
      for (int k = 0; k <= t; k++) begin
        acc += longint'(tap_mem[k]) * longint'(hist_mem[t - k]);
      end
      y = bound_sym(acc >>> FRAC_BITS, m_clamp);
      if (!m_bypass) begin
        y = bound_sym((longint'(gate_mem[t]) * y) >>> FRAC_BITS, m_clamp);
        if (y == longint'(m_clamp) || y == -longint'(m_clamp)) begin
          o.sat = 1'b1;
          viol_total = viol_total + 32'd1;
        end
      end
      o.y = y[31:0];
      o.last = (t == TAPS - 1);
      seq_pos = o.last ? 0 : t + 1;
      o.viol = viol_total;
    end
    conv_results_q.push_back(o);
  endtask

  // Draws one beat of the random stimulus. Reinits are rare so that most sequences run to
  // their final position; sample magnitudes are mixed so that both clean and saturated
  // results are common.
  function automatic conv_beat_t random_beat();
    conv_beat_t         b;
    logic signed [31:0] raw;
    raw = $urandom;
    b.cmd = ($urandom_range(0, 99) == 0) ? CMD_REINIT : CMD_SAMPLE;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b.x = raw >>> 13;
      4, 5:       b.x = raw >>> 7;
      6: begin
        case ($urandom_range(0, 3))
          0:       b.x = 32'sh7FFFFFFF;
          1:       b.x = 32'sh80000000;
          2:       b.x = '0;
          default: b.x = -32'sd1;
        endcase
      end
      default:    b.x = raw;
    endcase
    return b;
  endfunction

  task automatic queue_beat(input conv_cmd_e cmd, input logic signed [31:0] x);
    conv_beat_t b;
    b.cmd = cmd;
    b.x = x;
    sample_beats_q.push_back(b);
  endtask

  // Waits until every queued beat has gone in and every expected result has come out. The
  // check runs at the falling edge so that it sees the settled queues; it returns at a rising
  // edge so that register writes start on the clock.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (sample_beats_q.size() != 0 || item_valid || conv_results_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SEED:  m_seed = data;
      CFG_GAMMA: m_gamma = data[16:0];
      CFG_CLAMP: m_clamp = data[30:0];
      default:   m_bypass = data[0];
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [63:0] seed, input logic [16:0] gamma,
                                input logic [30:0] clamp, input logic bypass);
    write_reg(CFG_SEED, seed);
    write_reg(CFG_GAMMA, 64'(gamma));
    write_reg(CFG_CLAMP, 64'(clamp));
    write_reg(CFG_BYPASS, 64'(bypass));
    cfg_we <= 1'b0;
  endtask

  // Driver: presents one beat at a time from the pending queue. After every accepted beat it
  // draws how many cycles to hold off before the next one; now and then it switches into a
  // steady mode with no hold-off at all, so that back-to-back beats are exercised too.
  int         feed_wait = 0;
  logic       feed_steady = 1'b0;
  conv_beat_t cur_beat;

  always @(posedge clk) begin
    logic presenting;
    if (rst) begin
      item_valid <= 1'b0;
      feed_wait = 0;
    end else begin
      presenting = item_valid;
      if (item_valid && !item_stall) begin
        predict_beat(cur_beat);
        presenting = 1'b0;
        if ($urandom_range(0, 31) == 0) feed_steady = !feed_steady;
        feed_wait = feed_steady ? 0 : $urandom_range(0, 16);
      end
      if (!presenting) begin
        if (feed_wait > 0) begin
          feed_wait--;
        end else if (sample_beats_q.size() != 0) begin
          cur_beat = sample_beats_q.pop_front();
          command <= cur_beat.cmd;
          sample <= cur_beat.x;
          presenting = 1'b1;
        end
      end
      // A single assignment per cycle keeps valid high across back-to-back beats.
      item_valid <= presenting;
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, seen);
      err_count++;
    end
  endtask

  // Monitor: compares every accepted result beat, field by field, with the oldest
  // expectation. After each beat the receiver draws a random stall, with its own steady
  // stretches in which it never stalls.
  int   drain_hold = 0;
  logic drain_steady = 1'b0;

  always @(posedge clk) begin
    conv_out_t want;
    if (rst) begin
      res_stall <= 1'b0;
      drain_hold = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (conv_results_q.size() == 0) begin
          $error("result beat with no expectation waiting: result %0d", out_result);
          err_count++;
        end else begin
          want = conv_results_q.pop_front();
          check_field("result", want.y, out_result);
          check_field("saturated", {63'b0, want.sat}, {63'b0, out_saturated});
          check_field("last", {63'b0, want.last}, {63'b0, out_last});
          check_field("violation_count", {32'b0, want.viol}, {32'b0, out_violations});
        end
        if ($urandom_range(0, 31) == 0) drain_steady = !drain_steady;
        drain_hold = drain_steady ? 0 : $urandom_range(0, 16);
      end
      if (drain_hold > 0) begin
        drain_hold--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("gated_causal_long_convolution_unit verification failed");
    $finish;
  end

  // Stimulus: a directed opening at the reset configuration, then phases that each write
  // all four registers and run a stretch of random beats.
  initial begin
    logic [63:0] p_seed;
    logic [16:0] p_gamma;
    logic [30:0] p_clamp;
    logic        p_bypass;

    // The predictor starts from the reset state of the block.
    m_seed = '0;
    m_gamma = RESET_GAMMA;
    m_clamp = RESET_CLAMP;
    m_bypass = 1'b0;
    for (int k = 0; k < TAPS; k++) begin
      tap_mem[k] = '0;
      gate_mem[k] = '0;
      hist_mem[k] = '0;
    end
    seq_pos = 0;
    viol_total = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Before the first reinit the taps and gates are zero, so every result is zero.
    queue_beat(CMD_SAMPLE, 32'sh7FFFFFFF);
    queue_beat(CMD_SAMPLE, 32'sh80000000);
    queue_beat(CMD_SAMPLE, 32'sh12345678);
    // A reinit ignores its sample field; the seed is still zero, so the default is used.
    queue_beat(CMD_REINIT, 32'shDEADBEEF);
    queue_beat(CMD_SAMPLE, 32'sh7FFFFFFF);
    queue_beat(CMD_SAMPLE, 32'sh7FFFFFFF);
    queue_beat(CMD_SAMPLE, 32'sh80000000);
    queue_beat(CMD_SAMPLE, 32'sh80000000);
    queue_beat(CMD_SAMPLE, '0);
    queue_beat(CMD_SAMPLE, -32'sd1);
    queue_beat(CMD_SAMPLE, 32'sd1);
    queue_beat(CMD_SAMPLE, 32'sh00010000);
    queue_beat(CMD_SAMPLE, -32'sh00010000);
    queue_beat(CMD_SAMPLE, 32'sh00400000);
    queue_beat(CMD_SAMPLE, -32'sh00400000);
    queue_beat(CMD_SAMPLE, 32'sh55555555);
    queue_beat(CMD_SAMPLE, 32'shAAAAAAAA);
    // A reinit in the middle of a sequence restarts it at position zero.
    queue_beat(CMD_REINIT, '0);
    queue_beat(CMD_SAMPLE, 32'sh7FFFFFFF);
    queue_beat(CMD_SAMPLE, 32'sh80000000);
    queue_beat(CMD_SAMPLE, 32'sh0000FFFF);
    wait_idle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      p_seed = {$urandom, $urandom};
      p_gamma = 17'($urandom_range(0, 65536));
      p_clamp = 31'($urandom);
      p_bypass = 1'b0;
      case (p)
        0: begin
          p_gamma = RESET_GAMMA;
          p_clamp = RESET_CLAMP;
        end
        1: begin
          // Largest seed, unit gamma and the widest clamp.
          p_seed = '1;
          p_gamma = ONE_Q16;
          p_clamp = '1;
        end
        2: begin
          // Zero gamma leaves only the first tap; a zero clamp makes every gated result
          // zero and a violation.
          p_seed = 64'd1;
          p_gamma = '0;
          p_clamp = '0;
        end
        3: begin
          // Gamma above one is used as one.
          p_gamma = '1;
          p_bypass = 1'b1;
        end
        4: begin
          p_seed = '0;
          p_clamp = 31'($urandom_range(0, 1 << 20));
        end
        5: begin
          p_clamp = '0;
          p_bypass = 1'b1;
        end
        6: begin
          p_gamma = ONE_Q16 - 17'd1;
          p_clamp = '1;
          p_bypass = 1'b1;
        end
        default: p_bypass = 1'($urandom);
      endcase
      apply_settings(p_seed, p_gamma, p_clamp, p_bypass);
      @(negedge clk);
      // Most phases start with a reinit; the others keep the taps and the sequence
      // position across the register change.
      if (p == 0 || $urandom_range(0, 3) != 0) queue_beat(CMD_REINIT, 32'($urandom));
      repeat (ITEMS_PER_PHASE) sample_beats_q.push_back(random_beat());
      wait_idle();
    end

    // Let a regeneration's worth of cycles pass so that a stray beat would still be seen.
    repeat (4 * TAPS + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("gated_causal_long_convolution_unit verification clean");
    end else begin
      $display("gated_causal_long_convolution_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: gated_causal_long_convolution_unit.f
src/gclc_pkg.sv
src/gclc_mac.sv
src/gated_causal_long_convolution_unit.sv
tb/sv/tb_gated_causal_long_convolution_unit.sv
